FILE: rtl/core/bst_pkg.sv
// shared types, codes and helpers for the barrier state tracker
`timescale 1ns / 1ps

package bst_pkg;

	// request operation codes
	localparam logic [1:0] OP_TRANSITION = 2'd0;
	localparam logic [1:0] OP_UAV        = 2'd1;
	localparam logic [1:0] OP_ALIAS      = 2'd2;
	localparam logic [1:0] OP_CLEAR      = 2'd3;

	// emitted barrier kinds
	localparam logic [1:0] KIND_RESOLVED = 2'd0;
	localparam logic [1:0] KIND_UAV      = 2'd1;
	localparam logic [1:0] KIND_ALIAS    = 2'd2;
	localparam logic [1:0] KIND_PENDING  = 2'd3;

	// sequencer states
	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_ERD   = 9'b000000010,
		ST_ECMP  = 9'b000000100,
		ST_MISS  = 9'b000001000,
		ST_WHOLE = 9'b000010000,
		ST_SRD   = 9'b000100000,
		ST_SCMP  = 9'b001000000,
		ST_AFIN  = 9'b010000000,
		ST_SUPD  = 9'b100000000
	} state_t;

	// one subresource slot
	typedef struct packed {
		logic [15:0] idx;
		logic [31:0] state;
	} sub_word_t;

	// one latched request
	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] resource_id;
		logic [31:0] second_resource_id;
		logic        all_subres;
		logic [15:0] subresource_index;
		logic [31:0] state_before_in;
		logic [31:0] state_after;
		logic [1:0]  barrier_flags;
	} req_t;

	// one emitted barrier
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] res;
		logic [31:0] res2;
		logic        all;
		logic [15:0] sub;
		logic [31:0] st_before;
		logic [31:0] after;
		logic [1:0]  flags;
		logic        last;
		logic        ovf;
	} out_item_t;

	function automatic out_item_t mk_item(logic [1:0] kind, logic [31:0] res,
			logic [31:0] res2, logic all, logic [15:0] sub, logic [31:0] st_before,
			logic [31:0] after, logic [1:0] flags, logic last, logic ovf);
		out_item_t it;
		it.kind      = kind;
		it.res       = res;
		it.res2      = res2;
		it.all       = all;
		it.sub       = sub;
		it.st_before = st_before;
		it.after     = after;
		it.flags     = flags;
		it.last      = last;
		it.ovf       = ovf;
		return it;
	endfunction

endpackage

FILE: rtl/core/bst_ram.sv
// simple dual port synchronous ram with registered read
`timescale 1ns / 1ps

module bst_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/barrier_state_tracker.sv
// top level: resource state table with transition barrier sequencer
`timescale 1ns / 1ps

// Tracks resource and subresource states and turns transition requests into
// barriers. One request is taken at a time; req_stall stays high while the
// sequencer is busy and while a barrier waits in the output register, so the
// last barrier of a request has to be taken before the next request. A
// transition sweeps the entry ram, a read and a compare per entry, up to the
// match; an unknown resource sweeps every entry and then emits the pending
// barrier and inserts the resource, while a known one walks the subresource
// ram, a read and a compare per tracked slot, and then writes back. Waiting
// on rsp_stall stretches these steps. Valid bits live in flip-flops, so there
// is no clearing pass after reset.
module barrier_state_tracker #(
	parameter int MAX_RESOURCES    = 64,
	parameter int MAX_SUBRESOURCES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] resource_id,
	input  logic [31:0] second_resource_id,
	input  logic        all_subres,
	input  logic [15:0] subresource_index,
	input  logic [31:0] state_before_in,
	input  logic [31:0] state_after,
	input  logic [1:0]  barrier_flags,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  barrier_kind,
	output logic [31:0] out_resource,
	output logic [31:0] out_second_resource,
	output logic        out_all_subres,
	output logic [15:0] out_subresource,
	output logic [31:0] out_state_before,
	output logic [31:0] out_state_after,
	output logic [1:0]  out_flags,
	output logic        last,
	output logic        overflow
);

	localparam int RW  = $clog2(MAX_RESOURCES);
	localparam int SW  = $clog2(MAX_SUBRESOURCES);
	localparam int CW  = $clog2(MAX_SUBRESOURCES + 1);
	localparam int SD  = MAX_RESOURCES * MAX_SUBRESOURCES;
	localparam int AW  = $clog2(SD);
	localparam int EWW = 64 + CW;
	localparam logic [RW-1:0] LAST_ENTRY = RW'(MAX_RESOURCES - 1);
	localparam logic [CW-1:0] SUB_FULL   = CW'(MAX_SUBRESOURCES);

	bst_pkg::state_t    state_q;
	bst_pkg::req_t      req_q;
	bst_pkg::out_item_t out_q, held_q;
	logic               out_valid_q, held_v_q;
	logic [MAX_RESOURCES-1:0] valid_q;
	logic [RW-1:0]      ei_q, e_q, free_q;
	logic               free_v_q;
	logic [31:0]        whole_q, before_q;
	logic [CW-1:0]      cnt_q;
	logic [SW-1:0]      j_q, slot_q;
	logic               slot_v_q;

	// ram ports
	logic               ent_we, ent_re;
	logic [RW-1:0]      ent_waddr;
	logic [EWW-1:0]     ent_wdata, ent_rdata;
	logic               sub_we, sub_re;
	logic [AW-1:0]      sub_waddr, sub_raddr;
	bst_pkg::sub_word_t sub_wdata, sub_rdata;

	bst_ram #(.DEPTH(MAX_RESOURCES), .WIDTH(EWW)) u_ent (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.re(ent_re), .raddr(ei_q), .rdata(ent_rdata)
	);

	bst_ram #(.DEPTH(SD), .WIDTH($bits(bst_pkg::sub_word_t))) u_sub (
		.clk(clk), .we(sub_we), .waddr(sub_waddr), .wdata(sub_wdata),
		.re(sub_re), .raddr(sub_raddr), .rdata(sub_rdata)
	);

	// entry word fields
	logic [31:0]   rd_handle, rd_whole;
	logic [CW-1:0] rd_cnt;
	assign rd_handle = ent_rdata[EWW-1 -: 32];
	assign rd_whole  = ent_rdata[CW +: 32];
	assign rd_cnt    = ent_rdata[CW-1:0];

	// handshake
	logic req_acc, out_free;
	assign req_stall = (state_q != bst_pkg::ST_IDLE) || out_valid_q;
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !out_valid_q || !rsp_stall;

	// decisions of the current cycle
	logic      hit, ent_last, j_last, sub_diff, sub_new, cnt_full, single_emit;
	assign hit       = valid_q[ei_q] && (rd_handle == req_q.resource_id);
	assign ent_last  = (ei_q == LAST_ENTRY);
	assign j_last    = (CW'(j_q) == cnt_q - CW'(1));
	assign sub_diff  = sub_rdata.state != req_q.state_after;
	assign cnt_full  = (cnt_q == SUB_FULL);
	assign sub_new   = !slot_v_q && !cnt_full;
	assign single_emit = before_q != req_q.state_after;
	assign sub_raddr = AW'(e_q) * AW'(MAX_SUBRESOURCES) + AW'(j_q);

	// stall points of the sequencer
	logic go_miss, go_whole, go_scmp, go_afin, go_supd;
	assign go_miss  = out_free;
	assign go_whole = out_free || (whole_q == req_q.state_after);
	assign go_scmp  = !req_q.all_subres || !sub_diff || !held_v_q || out_free;
	assign go_afin  = out_free || !held_v_q;
	assign go_supd  = out_free || !single_emit;

	// output register is loaded this cycle
	logic out_set;
	always_comb begin
		case (state_q)
			bst_pkg::ST_IDLE:  out_set = req_acc
				&& (operation inside {bst_pkg::OP_UAV, bst_pkg::OP_ALIAS});
			bst_pkg::ST_MISS:  out_set = go_miss;
			bst_pkg::ST_WHOLE: out_set = go_whole && (whole_q != req_q.state_after);
			bst_pkg::ST_SCMP:  out_set = go_scmp && req_q.all_subres && sub_diff && held_v_q;
			bst_pkg::ST_AFIN:  out_set = go_afin && held_v_q;
			bst_pkg::ST_SUPD:  out_set = go_supd && single_emit;
			default:           out_set = 1'b0;
		endcase
	end

	// ram write and read control
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = e_q;
		ent_wdata = {req_q.resource_id, req_q.state_after, CW'(0)};
		sub_we    = 1'b0;
		sub_waddr = AW'(e_q) * AW'(MAX_SUBRESOURCES);
		sub_wdata = '{idx: req_q.subresource_index, state: req_q.state_after};
		ent_re    = (state_q == bst_pkg::ST_ERD);
		sub_re    = (state_q == bst_pkg::ST_SRD);
		case (state_q)
			bst_pkg::ST_MISS: begin
				ent_waddr = free_q;
				sub_waddr = AW'(free_q) * AW'(MAX_SUBRESOURCES);
				ent_we    = go_miss && free_v_q;
				sub_we    = go_miss && free_v_q && !req_q.all_subres;
				if (!req_q.all_subres) begin
					ent_wdata = {req_q.resource_id, 32'd0, CW'(1)};
				end
			end
			bst_pkg::ST_WHOLE: ent_we = go_whole;
			bst_pkg::ST_AFIN:  ent_we = go_afin;
			bst_pkg::ST_SUPD: begin
				if (slot_v_q) begin
					sub_we    = go_supd;
					sub_waddr = AW'(e_q) * AW'(MAX_SUBRESOURCES) + AW'(slot_q);
				end else if (sub_new) begin
					sub_we    = go_supd;
					ent_we    = go_supd;
					sub_waddr = AW'(e_q) * AW'(MAX_SUBRESOURCES) + AW'(cnt_q);
					ent_wdata = {req_q.resource_id, whole_q, cnt_q + CW'(1)};
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bst_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			held_v_q    <= 1'b0;
			valid_q     <= '0;
			free_v_q    <= 1'b0;
			slot_v_q    <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && rsp_stall);
			case (state_q)
				bst_pkg::ST_IDLE: begin
					if (req_acc) begin
						req_q <= '{operation, resource_id, second_resource_id,
							all_subres, subresource_index, state_before_in,
							state_after, barrier_flags};
						case (operation)
							bst_pkg::OP_UAV: begin
								out_q <= bst_pkg::mk_item(bst_pkg::KIND_UAV, resource_id,
									32'd0, 1'b0, 16'd0, 32'd0, 32'd0, barrier_flags,
									1'b1, 1'b0);
							end
							bst_pkg::OP_ALIAS: begin
								out_q <= bst_pkg::mk_item(bst_pkg::KIND_ALIAS, resource_id,
									second_resource_id, 1'b0, 16'd0, 32'd0, 32'd0,
									barrier_flags, 1'b1, 1'b0);
							end
							bst_pkg::OP_CLEAR: valid_q <= '0;
							default: begin
								if (resource_id != 32'd0) begin
									ei_q     <= '0;
									free_v_q <= 1'b0;
									state_q  <= bst_pkg::ST_ERD;
								end
							end
						endcase
					end
				end
				bst_pkg::ST_ERD: state_q <= bst_pkg::ST_ECMP;
				bst_pkg::ST_ECMP: begin
					if (hit) begin
						e_q      <= ei_q;
						whole_q  <= rd_whole;
						before_q <= rd_whole;
						cnt_q    <= rd_cnt;
						j_q      <= '0;
						slot_v_q <= 1'b0;
						held_v_q <= 1'b0;
						if (rd_cnt == CW'(0)) begin
							state_q <= req_q.all_subres ? bst_pkg::ST_WHOLE
								: bst_pkg::ST_SUPD;
						end else begin
							state_q <= bst_pkg::ST_SRD;
						end
					end else begin
						if (!valid_q[ei_q] && !free_v_q) begin
							free_q   <= ei_q;
							free_v_q <= 1'b1;
						end
						if (ent_last) begin
							state_q <= bst_pkg::ST_MISS;
						end else begin
							ei_q    <= ei_q + RW'(1);
							state_q <= bst_pkg::ST_ERD;
						end
					end
				end
				// unknown resource: pending barrier and insert
				bst_pkg::ST_MISS: begin
					if (go_miss) begin
						out_q <= bst_pkg::mk_item(bst_pkg::KIND_PENDING, req_q.resource_id,
							32'd0, req_q.all_subres,
							req_q.all_subres ? 16'd0 : req_q.subresource_index,
							req_q.state_before_in, req_q.state_after, req_q.barrier_flags,
							1'b1, !free_v_q);
						if (free_v_q) begin
							valid_q[free_q] <= 1'b1;
						end
						state_q <= bst_pkg::ST_IDLE;
					end
				end
				// whole resource with no tracked slots
				bst_pkg::ST_WHOLE: begin
					if (go_whole) begin
						if (whole_q != req_q.state_after) begin
							out_q <= bst_pkg::mk_item(bst_pkg::KIND_RESOLVED,
								req_q.resource_id, 32'd0, 1'b1, 16'd0, whole_q,
								req_q.state_after, req_q.barrier_flags, 1'b1, 1'b0);
						end
						state_q <= bst_pkg::ST_IDLE;
					end
				end
				bst_pkg::ST_SRD: state_q <= bst_pkg::ST_SCMP;
				// slot compare; all-mode keeps one barrier back to mark the last
				bst_pkg::ST_SCMP: begin
					if (go_scmp) begin
						if (req_q.all_subres) begin
							if (sub_diff) begin
								if (held_v_q) begin
									out_q <= held_q;
								end
								held_q <= bst_pkg::mk_item(bst_pkg::KIND_RESOLVED,
									req_q.resource_id, 32'd0, 1'b0, sub_rdata.idx,
									sub_rdata.state, req_q.state_after,
									req_q.barrier_flags, 1'b0, 1'b0);
								held_v_q <= 1'b1;
							end
						end else if (sub_rdata.idx == req_q.subresource_index) begin
							slot_q   <= j_q;
							slot_v_q <= 1'b1;
							before_q <= sub_rdata.state;
						end
						if (j_last) begin
							state_q <= req_q.all_subres ? bst_pkg::ST_AFIN
								: bst_pkg::ST_SUPD;
						end else begin
							j_q     <= j_q + SW'(1);
							state_q <= bst_pkg::ST_SRD;
						end
					end
				end
				bst_pkg::ST_AFIN: begin
					if (go_afin) begin
						if (held_v_q) begin
							out_q <= bst_pkg::mk_item(held_q.kind, held_q.res, held_q.res2,
								held_q.all, held_q.sub, held_q.st_before, held_q.after,
								held_q.flags, 1'b1, held_q.ovf);
						end
						held_v_q <= 1'b0;
						state_q  <= bst_pkg::ST_IDLE;
					end
				end
				// single subresource update
				bst_pkg::ST_SUPD: begin
					if (go_supd) begin
						if (single_emit) begin
							out_q <= bst_pkg::mk_item(bst_pkg::KIND_RESOLVED,
								req_q.resource_id, 32'd0, 1'b0, req_q.subresource_index,
								before_q, req_q.state_after, req_q.barrier_flags, 1'b1,
								!slot_v_q && cnt_full);
						end
						state_q <= bst_pkg::ST_IDLE;
					end
				end
				default: state_q <= bst_pkg::ST_IDLE;
			endcase
		end
	end

	// output ports
	assign rsp_valid            = out_valid_q;
	assign barrier_kind         = out_q.kind;
	assign out_resource         = out_q.res;
	assign out_second_resource  = out_q.res2;
	assign out_all_subres       = out_q.all;
	assign out_subresource      = out_q.sub;
	assign out_state_before     = out_q.st_before;
	assign out_state_after      = out_q.after;
	assign out_flags            = out_q.flags;
	assign last                 = out_q.last;
	assign overflow             = out_q.ovf;

	// checks
	a_pass_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (barrier_kind == bst_pkg::KIND_UAV
			|| barrier_kind == bst_pkg::KIND_ALIAS) |-> last && !overflow)
		else $error("pass-through barrier not single");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && operation == bst_pkg::OP_CLEAR |=> valid_q == '0)
		else $error("clear left valid entries");

	a_ovf_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow |-> barrier_kind == bst_pkg::KIND_RESOLVED
			|| barrier_kind == bst_pkg::KIND_PENDING)
		else $error("overflow on pass-through barrier");

	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		held_v_q |-> state_q == bst_pkg::ST_SRD || state_q == bst_pkg::ST_SCMP
			|| state_q == bst_pkg::ST_AFIN)
		else $error("held barrier outside slot walk");

endmodule

FILE: tb/bst_checker.sv
// checker: predicts barriers from accepted requests and compares them with the block output
`timescale 1ns / 1ps

module bst_checker #(
	parameter int MAX_RESOURCES    = 64,
	parameter int MAX_SUBRESOURCES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] resource_id,
	input  logic [31:0] second_resource_id,
	input  logic        all_subres,
	input  logic [15:0] subresource_index,
	input  logic [31:0] state_before_in,
	input  logic [31:0] state_after,
	input  logic [1:0]  barrier_flags,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [1:0]  barrier_kind,
	input  logic [31:0] out_resource,
	input  logic [31:0] out_second_resource,
	input  logic        out_all_subres,
	input  logic [15:0] out_subresource,
	input  logic [31:0] out_state_before,
	input  logic [31:0] out_state_after,
	input  logic [1:0]  out_flags,
	input  logic        last,
	input  logic        overflow,
	output int          fail_count,
	output int          pending_barriers
);

	// shadow copy of the resource table
	logic        ent_valid [MAX_RESOURCES];
	logic [31:0] ent_handle [MAX_RESOURCES];
	logic [31:0] ent_whole [MAX_RESOURCES];
	int          ent_count [MAX_RESOURCES];
	logic [15:0] slot_idx [MAX_RESOURCES][MAX_SUBRESOURCES];
	logic [31:0] slot_state [MAX_RESOURCES][MAX_SUBRESOURCES];

	bst_pkg::out_item_t expected_barriers[$];

	assign pending_barriers = expected_barriers.size();

	// work out the barriers caused by one request and update the shadow table
	task automatic predict_barriers(input bst_pkg::req_t r);
		bst_pkg::out_item_t batch[$];
		int e, f, slot, i;
		logic [31:0] prior;
		logic ovf;
		e = -1;
		f = -1;
		slot = -1;
		ovf = 1'b0;
		case (r.operation)
			bst_pkg::OP_UAV:
				batch = {batch, bst_pkg::mk_item(bst_pkg::KIND_UAV, r.resource_id, 32'd0,
					1'b0, 16'd0, 32'd0, 32'd0, r.barrier_flags, 1'b0, 1'b0)};
			bst_pkg::OP_ALIAS:
				batch = {batch, bst_pkg::mk_item(bst_pkg::KIND_ALIAS, r.resource_id,
					r.second_resource_id, 1'b0, 16'd0, 32'd0, 32'd0, r.barrier_flags,
					1'b0, 1'b0)};
			bst_pkg::OP_CLEAR:
				for (i = 0; i < MAX_RESOURCES; i++) ent_valid[i] = 1'b0;
			default: begin
				if (r.resource_id != 32'd0) begin
					for (i = MAX_RESOURCES - 1; i >= 0; i--) begin
						if (ent_valid[i] && ent_handle[i] == r.resource_id) e = i;
						if (!ent_valid[i]) f = i;
					end
					if (e >= 0 && r.all_subres) begin
						// whole-resource transition on a known resource
						if (ent_count[e] > 0) begin
							for (i = 0; i < ent_count[e]; i++)
								if (slot_state[e][i] != r.state_after)
									batch = {batch, bst_pkg::mk_item(bst_pkg::KIND_RESOLVED,
										r.resource_id, 32'd0, 1'b0, slot_idx[e][i],
										slot_state[e][i], r.state_after, r.barrier_flags,
										1'b0, 1'b0)};
						end else if (ent_whole[e] != r.state_after) begin
							batch = {batch, bst_pkg::mk_item(bst_pkg::KIND_RESOLVED,
								r.resource_id, 32'd0, 1'b1, 16'd0, ent_whole[e],
								r.state_after, r.barrier_flags, 1'b0, 1'b0)};
						end
						ent_whole[e] = r.state_after;
						ent_count[e] = 0;
					end else if (e >= 0) begin
						// single subresource on a known resource
						prior = ent_whole[e];
						for (i = 0; i < ent_count[e]; i++)
							if (slot_idx[e][i] == r.subresource_index) begin
								prior = slot_state[e][i];
								slot = i;
							end
						if (slot >= 0) begin
							slot_state[e][slot] = r.state_after;
						end else if (ent_count[e] < MAX_SUBRESOURCES) begin
							slot_idx[e][ent_count[e]] = r.subresource_index;
							slot_state[e][ent_count[e]] = r.state_after;
							ent_count[e]++;
						end else begin
							ovf = 1'b1;
						end
						if (prior != r.state_after)
							batch = {batch, bst_pkg::mk_item(bst_pkg::KIND_RESOLVED,
								r.resource_id, 32'd0, 1'b0, r.subresource_index, prior,
								r.state_after, r.barrier_flags, 1'b0, 1'b0)};
					end else begin
						// unknown resource: pending barrier and insert
						batch = {batch, bst_pkg::mk_item(bst_pkg::KIND_PENDING,
							r.resource_id, 32'd0, r.all_subres,
							r.all_subres ? 16'd0 : r.subresource_index,
							r.state_before_in, r.state_after, r.barrier_flags, 1'b0, 1'b0)};
						if (f < 0) begin
							ovf = 1'b1;
						end else begin
							ent_valid[f] = 1'b1;
							ent_handle[f] = r.resource_id;
							if (r.all_subres) begin
								ent_whole[f] = r.state_after;
								ent_count[f] = 0;
							end else begin
								ent_whole[f] = 32'd0;
								slot_idx[f][0] = r.subresource_index;
								slot_state[f][0] = r.state_after;
								ent_count[f] = 1;
							end
						end
					end
				end
			end
		endcase
		foreach (batch[k]) begin
			batch[k].ovf = ovf;
			batch[k].last = (k == batch.size() - 1);
			expected_barriers = {expected_barriers, batch[k]};
		end
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		bst_pkg::out_item_t got, want;
		bst_pkg::req_t r;
		if (!arst_n) begin
			fail_count <= 0;
			expected_barriers.delete();
			for (int i = 0; i < MAX_RESOURCES; i++) begin
				ent_valid[i] = 1'b0;
				ent_count[i] = 0;
			end
		end else begin
			if (rsp_valid && !rsp_stall) begin
				got = bst_pkg::mk_item(barrier_kind, out_resource, out_second_resource,
					out_all_subres, out_subresource, out_state_before, out_state_after,
					out_flags, last, overflow);
				if (expected_barriers.size() == 0) begin
					if (fail_count < 10) $display("unexpected barrier %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_barriers.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("barrier mismatch: expected %h actual %h", want, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req_valid && !req_stall) begin
				r = '{operation, resource_id, second_resource_id, all_subres,
					subresource_index, state_before_in, state_after, barrier_flags};
				predict_barriers(r);
			end
		end
	end

endmodule

FILE: tb/tb.sv
// testbench top: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  operation = bst_pkg::OP_UAV;
	logic [31:0] resource_id = '0;
	logic [31:0] second_resource_id = '0;
	logic        all_subres = 1'b0;
	logic [15:0] subresource_index = '0;
	logic [31:0] state_before_in = '0;
	logic [31:0] state_after = '0;
	logic [1:0]  barrier_flags = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [1:0]  barrier_kind;
	logic [31:0] out_resource, out_second_resource, out_state_before, out_state_after;
	logic        out_all_subres, last, overflow;
	logic [15:0] out_subresource;
	logic [1:0]  out_flags;
	int          fail_count, pending_barriers;
	int          send_idle_pct = 0;
	int          stall_pct = 0;

	// small pool of handles so lookups hit often
	logic [31:0] handle_pool [8] = '{32'h1, 32'hFFFFFFFF, 32'h80000000, 32'h5, 32'h1234,
		32'hA5A5A5A5, 32'h7, 32'h9};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	barrier_state_tracker i_dut (.*);

	bst_checker i_checker (.*);

	// receiver stalls at random
	always @(posedge clk) rsp_stall <= ($urandom_range(99) < stall_pct);

	// send one request and wait for acceptance; valid stays up until the next call
	task automatic send_request(input logic [1:0] op, input logic [31:0] rid,
			input logic [31:0] rid2, input logic all, input logic [15:0] sub,
			input logic [31:0] sb, input logic [31:0] sa, input logic [1:0] fl);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		resource_id <= rid;
		second_resource_id <= rid2;
		all_subres <= all;
		subresource_index <= sub;
		state_before_in <= sb;
		state_after <= sa;
		barrier_flags <= fl;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// pick a mostly small state value so unchanged states occur
	function automatic logic [31:0] pick_state();
		return ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(3));
	endfunction

	initial begin
		logic [1:0] op;
		int roll;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pass-through, null transition, pending, resolved, unchanged
		send_request(bst_pkg::OP_UAV, 32'hFFFFFFFF, 32'd0, 1'b0, 16'd0, 32'd0, 32'd0, 2'd3);
		send_request(bst_pkg::OP_ALIAS, 32'h0, 32'hFFFFFFFF, 1'b1, 16'hFFFF, 32'hFFFFFFFF,
			32'd0, 2'd0);
		send_request(bst_pkg::OP_TRANSITION, 32'd0, 32'd0, 1'b1, 16'd0, 32'd1, 32'd2, 2'd0);
		send_request(bst_pkg::OP_TRANSITION, 32'h1, 32'd0, 1'b1, 16'd0, 32'hFFFFFFFF,
			32'h4, 2'd1);
		send_request(bst_pkg::OP_TRANSITION, 32'h1, 32'd0, 1'b1, 16'd0, 32'd0, 32'h4, 2'd2);
		send_request(bst_pkg::OP_TRANSITION, 32'h1, 32'd0, 1'b1, 16'd0, 32'd0,
			32'hFFFFFFFF, 2'd3);
		send_request(bst_pkg::OP_TRANSITION, 32'h1, 32'd0, 1'b0, 16'hFFFF, 32'd0,
			32'h8, 2'd0);
		send_request(bst_pkg::OP_TRANSITION, 32'h1, 32'd0, 1'b0, 16'h0, 32'd0, 32'h8, 2'd0);
		send_request(bst_pkg::OP_TRANSITION, 32'h1, 32'd0, 1'b1, 16'd0, 32'd0, 32'h10, 2'd1);
		send_request(bst_pkg::OP_TRANSITION, 32'h2, 32'd0, 1'b0, 16'h3, 32'h11, 32'h0, 2'd0);
		// fill the subresource slots of one resource past capacity
		for (int i = 0; i < 18; i++)
			send_request(bst_pkg::OP_TRANSITION, 32'h2, 32'd0, 1'b0, 16'(i), 32'd0,
				32'h1, 2'd0);
		send_request(bst_pkg::OP_TRANSITION, 32'h2, 32'd0, 1'b1, 16'd0, 32'd0, 32'h2, 2'd3);
		// fill the resource table past capacity, then clear
		for (int i = 0; i < 66; i++)
			send_request(bst_pkg::OP_TRANSITION, 32'h100 + 32'(i), 32'd0, 1'b1, 16'd0,
				32'(i), 32'(i), 2'd1);
		send_request(bst_pkg::OP_CLEAR, 32'd0, 32'd0, 1'b0, 16'd0, 32'd0, 32'd0, 2'd0);
		send_request(bst_pkg::OP_TRANSITION, 32'h100, 32'd0, 1'b1, 16'd0, 32'd0,
			32'h1, 2'd0);

		// random phases with different idling
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 66 : (phase == 3) ? 25 : 0;
			stall_pct = (phase == 2) ? 66 : (phase == 3) ? 25 : 0;
			for (int n = 0; n < 50; n++) begin
				roll = $urandom_range(99);
				op = (roll < 80) ? bst_pkg::OP_TRANSITION : (roll < 88) ? bst_pkg::OP_UAV :
					(roll < 96) ? bst_pkg::OP_ALIAS : bst_pkg::OP_CLEAR;
				send_request(op, ($urandom_range(9) == 0) ? $urandom() :
					handle_pool[$urandom_range(7)], $urandom(), 1'($urandom_range(3) == 0),
					($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(17)),
					$urandom(), pick_state(), 2'($urandom_range(3)));
			end
			// hold off until every barrier has come out
			req_valid <= 1'b0;
			@(posedge clk);
			while (pending_barriers != 0) @(posedge clk);
		end

		stall_pct = 0;
		while (pending_barriers != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_barriers == 0)
			$display("PASS barrier_state_tracker");
		else
			$display("FAIL barrier_state_tracker");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAIL barrier_state_tracker");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/bst_pkg.sv
rtl/core/bst_ram.sv
rtl/core/barrier_state_tracker.sv
tb/bst_checker.sv
tb/tb.sv
